// ===== hdl/ptoc_pkg.sv =====
// shared types and constants for the periodic timer with overrun count
package ptoc_pkg;

  localparam int TIME_W     = 64;
  localparam int IN_DATA_W  = 3 * TIME_W;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 200;
  localparam int STEP_W     = $clog2(TIME_W);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ARM   = 2'd1,
    OP_READ  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_DIV,
    ST_FIX_COUNT,
    ST_FIX_DEADLINE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic div_init;
    logic div_step;
    logic fix_count;
    logic fix_deadline;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic hit;
    logic periodic;
    logic late;
    logic div_last;
  } sts_t;

endpackage

// ===== hdl/ptoc_ctrl.sv =====
// sequencer for the timer operations and the catch-up division
module ptoc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  ptoc_pkg::sts_t  sts,
  output ptoc_pkg::cmd_t  cmd
);
  import ptoc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == OP_TICK && sts.hit && sts.periodic) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        // stepped deadline still not after now: skip the missed periods
        if (sts.late) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIX_COUNT;
        end
      end
      ST_FIX_COUNT: begin
        cmd.fix_count = 1'b1;
        state_nxt     = ST_FIX_DEADLINE;
      end
      ST_FIX_DEADLINE: begin
        cmd.fix_deadline = 1'b1;
        state_nxt        = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !cmd.out_load)
    else $error("pending result overwritten");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_EXEC)
    else $error("accepted transaction not executed");

  a_div_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && !sts.div_last |=> state_r == ST_DIV)
    else $error("division left early");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !cmd.load)
    else $error("load while busy");
`endif

endmodule

// ===== hdl/ptoc_dp.sv =====
// timer state, serial divider and result register
module ptoc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ptoc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [ptoc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic [ptoc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  ptoc_pkg::cmd_t                    cmd,
  output ptoc_pkg::sts_t                    sts
);
  import ptoc_pkg::*;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // latched transaction
  op_t               op_r;
  logic              abs_r;
  logic [TIME_W-1:0] now_r, value_r, per_in_r;

  // timer state
  logic [TIME_W-1:0] deadline_r, period_r, cnt_r;

  // divider
  logic [TIME_W-1:0] quo_r, rem_r, base_r;
  logic [STEP_W-1:0] step_r;
  logic [TIME_W:0]   shifted, diff;

  // result
  logic              res_fired_r, res_status_r;
  logic [TIME_W-1:0] res_count_r, res_remaining_r, res_interval_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic              hit;
  logic [TIME_W:0]   cnt_sum;

  assign hit     = (deadline_r != '0) && (deadline_r <= now_r);
  assign shifted = {rem_r, quo_r[TIME_W-1]};
  assign diff    = shifted - {1'b0, period_r};
  // count plus skipped periods plus one, carry in
  assign cnt_sum = {1'b0, cnt_r} + {1'b0, quo_r} + {{TIME_W{1'b0}}, 1'b1};

  assign sts.op       = op_r;
  assign sts.hit      = hit;
  assign sts.periodic = (period_r != '0);
  assign sts.late     = (deadline_r <= now_r);
  assign sts.div_last = (step_r == {STEP_W{1'b1}});

  assign out_tdata = out_r;

  // transaction and working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= in_tdata[TIME_W-1:0];
      value_r  <= in_tdata[2*TIME_W-1:TIME_W];
      per_in_r <= in_tdata[3*TIME_W-1:2*TIME_W];
      op_r     <= op_t'(in_tuser[1:0]);
      abs_r    <= in_tuser[2];
    end
    if (cmd.exec) begin
      res_fired_r     <= 1'b0;
      res_status_r    <= 1'b0;
      res_count_r     <= '0;
      res_remaining_r <= '0;
      res_interval_r  <= '0;
      case (op_r)
        OP_TICK: begin
          res_fired_r <= hit;
        end
        OP_READ: begin
          if (cnt_r != '0) begin
            res_count_r <= cnt_r;
          end else begin
            res_status_r <= 1'b1;
          end
        end
        OP_QUERY: begin
          if (deadline_r != '0 && deadline_r > now_r) begin
            res_remaining_r <= deadline_r - now_r;
          end
          res_interval_r <= period_r;
        end
        default: begin
        end
      endcase
    end
    if (cmd.div_init) begin
      quo_r  <= now_r - deadline_r;
      rem_r  <= '0;
      step_r <= '0;
    end
    if (cmd.div_step) begin
      // restoring division, one quotient bit per cycle
      if (!diff[TIME_W]) begin
        rem_r <= diff[TIME_W-1:0];
      end else begin
        rem_r <= shifted[TIME_W-1:0];
      end
      quo_r  <= {quo_r[TIME_W-2:0], !diff[TIME_W]};
      step_r <= step_r + {{(STEP_W-1){1'b0}}, 1'b1};
    end
    if (cmd.fix_count) begin
      base_r <= now_r - rem_r;
    end
    if (cmd.out_load) begin
      out_r <= {{(OUT_DATA_W - 3*TIME_W - 3){1'b0}}, (cnt_r != '0),
                res_interval_r, res_remaining_r, res_status_r,
                res_count_r, res_fired_r};
    end
  end

  // architectural timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
      period_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.exec) begin
        case (op_r)
          OP_TICK: begin
            if (hit) begin
              cnt_r <= sat_add(cnt_r, {{(TIME_W-1){1'b0}}, 1'b1});
              if (period_r == '0) begin
                deadline_r <= '0;
              end else begin
                deadline_r <= sat_add(deadline_r, period_r);
              end
            end
          end
          OP_ARM: begin
            if (value_r == '0) begin
              deadline_r <= '0;
              period_r   <= '0;
            end else begin
              deadline_r <= abs_r ? value_r : sat_add(now_r, value_r);
              period_r   <= per_in_r;
            end
          end
          OP_READ: begin
            cnt_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.fix_count) begin
        cnt_r <= cnt_sum[TIME_W] ? {TIME_W{1'b1}} : cnt_sum[TIME_W-1:0];
      end
      if (cmd.fix_deadline) begin
        deadline_r <= sat_add(base_r, period_r);
      end
    end
  end

endmodule

// ===== hdl/periodic_timer_overrun_count_top.sv =====
// top level of the periodic timer with overrun count
//
//  channel | direction | tdata                                                | tuser
//  in_     | slave     | now, arm value, period (64 b each)                   | op, absolute
//  out_    | master    | fired, count, status, time left, interval, readable | -
//
// arm, read, query, a tick that does not fire and a one-shot tick that fires go
// through the exec and done states; a firing periodic tick also passes the check
// state; one that missed periods runs the 64-step restoring divider that counts them.
// reset is synchronous and active low; it disarms the timer and clears the count.
// a stalled result is held in the output register while the next transaction
// is accepted; a finished one waits until that register is free.
module periodic_timer_overrun_count_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // now_ns[63:0], arm_value[127:64], period_ns[191:128]
  input  logic [ptoc_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[1:0], absolute[2]
  input  logic [ptoc_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fired[0], expiration_count[64:1], status[65], time_left[129:66],
  // interval_now[193:130], readable[194], zero fill [199:195]
  output logic [ptoc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ptoc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptoc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ptoc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
